[sv/multi_channel_blink_sequencer_macros.svh]
// assertion helpers, sampled on clock and switched off while reset is high
`ifndef MULTI_CHANNEL_BLINK_SEQUENCER_MACROS_SVH
`define MULTI_CHANNEL_BLINK_SEQUENCER_MACROS_SVH

// condition holds at every edge
`define MCBS_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// antecedent at one edge implies consequent at the next
`define MCBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/mcbs_pkg.sv]
package mcbs_pkg;

   localparam int CHANNELS = 8;
   localparam int OUT_W = 8;
   localparam int CHAN_W = 3;
   localparam int REP_W = 8;
   localparam int HP_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_START = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ACTIVE_LOW_MASK = 3'd0;

   // per-channel command from the sequencer stage
   typedef struct packed {
      logic tick;
      logic start;
      logic initial_on;
      logic [REP_W-1:0] repeat_count;
      logic [HP_W-1:0] half_period;
   } mcbs_chan_ctrl_type;

   // per-channel state after the current transaction
   typedef struct packed {
      logic level;
      logic active;
   } mcbs_chan_status_type;

endpackage

[sv/mcbs_req_if.sv]
interface mcbs_req_if;
   logic valid;
   logic ready;
   logic command;
   logic [mcbs_pkg::CHAN_W-1:0] channel;
   logic initial_on;
   logic [mcbs_pkg::REP_W-1:0] repeat_count;
   logic [mcbs_pkg::HP_W-1:0] half_period;

   modport source (output valid, command, channel, initial_on, repeat_count, half_period,
                   input ready);
   modport sink (input valid, command, channel, initial_on, repeat_count, half_period,
                 output ready);
endinterface

[sv/mcbs_rsp_if.sv]
interface mcbs_rsp_if;
   logic valid;
   logic ready;
   logic [mcbs_pkg::OUT_W-1:0] pin_levels;
   logic [mcbs_pkg::OUT_W-1:0] active_mask;

   modport source (output valid, pin_levels, active_mask, input ready);
   modport sink (input valid, pin_levels, active_mask, output ready);
endinterface

[sv/mcbs_channel.sv]
`include "multi_channel_blink_sequencer_macros.svh"

module mcbs_channel (
   input  logic clock,
   input  logic reset,
   input  mcbs_pkg::mcbs_chan_ctrl_type ctrl,
   output mcbs_pkg::mcbs_chan_status_type status
);
   import mcbs_pkg::*;

   logic level_ff, level_in;
   logic next_ff, next_in;
   logic [HP_W-1:0] cnt_ff, cnt_in;
   logic [HP_W-1:0] per_ff, per_in;
   logic [REP_W-1:0] tot_ff, tot_in;
   logic [REP_W-1:0] left_ff, left_in;
   logic [HP_W-1:0] cnt_inc;
   logic [REP_W-1:0] left_dec;

   assign cnt_inc = cnt_ff + HP_W'(1);
   assign left_dec = left_ff - REP_W'(1);

   always_comb begin
      level_in = level_ff;
      next_in = next_ff;
      cnt_in = cnt_ff;
      per_in = per_ff;
      tot_in = tot_ff;
      left_in = left_ff;
      if (ctrl.start) begin
         level_in = ctrl.initial_on;
         next_in = !ctrl.initial_on;
         cnt_in = '0;
         per_in = ctrl.half_period;
         tot_in = ctrl.repeat_count;
         left_in = ctrl.repeat_count;
      end else if (ctrl.tick && (per_ff != '0)) begin
         if (cnt_inc != per_ff) begin
            cnt_in = cnt_inc;
         end else begin
            cnt_in = '0;
            if (next_ff) begin
               level_in = 1'b1;
               next_in = 1'b0;
            end else begin
               level_in = 1'b0;
               next_in = 1'b1;
               // off edge spends one blink unless the pattern is endless
               if (tot_ff != '0) begin
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     tot_in = '0;
                     per_in = '0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         next_ff <= 1'b0;
         cnt_ff <= '0;
         per_ff <= '0;
         tot_ff <= '0;
         left_ff <= '0;
      end else begin
         level_ff <= level_in;
         next_ff <= next_in;
         cnt_ff <= cnt_in;
         per_ff <= per_in;
         tot_ff <= tot_in;
         left_ff <= left_in;
      end
   end

   assign status.level = level_in;
   assign status.active = (per_in != '0);

   `MCBS_ASSERT_ALWAYS(a_count_below_period, (per_ff == '0) || (cnt_ff < per_ff))
   `MCBS_ASSERT_ALWAYS(a_finite_has_repeats, (tot_ff == '0) || (left_ff != '0))
   `MCBS_ASSERT_NEXT(a_idle_holds_level, !ctrl.start && (per_ff == '0), $stable(level_ff))
endmodule

[sv/multi_channel_blink_sequencer.sv]
// a transaction goes from the input register to the result register, which drives rsp_chan
// throughput: one transaction per cycle while rsp_chan.ready is high
// while a finished result waits to be taken, an empty input register takes one more
// transaction and then holds req_chan.ready low
// reset (synchronous, active high): all channels idle and off, polarity mask zero,
// both pipeline registers empty
`include "multi_channel_blink_sequencer_macros.svh"

module multi_channel_blink_sequencer (
   input  logic clock,
   input  logic reset,
   mcbs_req_if.sink req_chan,
   mcbs_rsp_if.source rsp_chan,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [mcbs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mcbs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mcbs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import mcbs_pkg::*;

   // polarity register
   logic [OUT_W-1:0] mask_ff, mask_in;

   // input register
   logic in_valid_ff, in_valid_in;
   logic in_command_ff;
   logic [CHAN_W-1:0] in_channel_ff;
   logic in_initial_on_ff;
   logic [REP_W-1:0] in_repeat_ff;
   logic [HP_W-1:0] in_half_ff;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] pin_ff, pin_in;
   logic [OUT_W-1:0] act_ff, act_in;

   logic req_fire;
   logic advance;
   logic stage_fire;
   logic csr_write;
   logic rsp_stall;

   mcbs_chan_ctrl_type ctrl [CHANNELS];
   mcbs_chan_status_type status [CHANNELS];
   logic [OUT_W-1:0] levels;

   // ---------------------------------------------------------------
   // configuration port: csr_pready is tied high
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign mask_in = (csr_write && (csr_paddr == ADDR_ACTIVE_LOW_MASK))
                    ? csr_pwdata[OUT_W-1:0] : mask_ff;
   assign csr_prdata = (csr_paddr == ADDR_ACTIVE_LOW_MASK)
                       ? {{(CSR_DATA_W-OUT_W){1'b0}}, mask_ff} : '0;

   // ---------------------------------------------------------------
   // handshake: the stage moves on when the result register is free or draining
   // ---------------------------------------------------------------
   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign stage_fire = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_stall = rsp_valid_ff && !rsp_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (stage_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stage_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // channel bank: a tick reaches every channel, a start only the addressed one;
   // a start for a channel beyond the bank matches nothing and is dropped
   // ---------------------------------------------------------------
   for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
      assign ctrl[g].tick = stage_fire && (in_command_ff == CMD_TICK);
      assign ctrl[g].start = stage_fire && (in_command_ff == CMD_START)
                             && (6'(in_channel_ff) == 6'(g));
      assign ctrl[g].initial_on = in_initial_on_ff;
      assign ctrl[g].repeat_count = in_repeat_ff;
      assign ctrl[g].half_period = in_half_ff;

      mcbs_channel u_channel (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl[g]),
         .status (status[g])
      );
   end

   // channel g drives bit g of the result fields; with OUT_W equal to CHANNELS, every channel shows
   for (genvar g = 0; g < OUT_W; g++) begin : g_out
      if (g < CHANNELS) begin : g_used
         assign levels[g] = status[g].level;
         assign act_in[g] = status[g].active;
      end else begin : g_unused
         assign levels[g] = 1'b0;
         assign act_in[g] = 1'b0;
      end
   end

   assign pin_in = levels ^ mask_ff;

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_command_ff <= req_chan.command;
         in_channel_ff <= req_chan.channel;
         in_initial_on_ff <= req_chan.initial_on;
         in_repeat_ff <= req_chan.repeat_count;
         in_half_ff <= req_chan.half_period;
      end
      if (stage_fire) begin
         pin_ff <= pin_in;
         act_ff <= act_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pin_levels = pin_ff;
   assign rsp_chan.active_mask = act_ff;

   // a full stage behind a stalled result must not take another transaction
   `MCBS_ASSERT_ALWAYS(a_no_overrun, !(in_valid_ff && rsp_stall) || !req_chan.ready)
   // every transaction through the stage leaves a result behind
   `MCBS_ASSERT_NEXT(a_stage_to_result, stage_fire, rsp_valid_ff)
   // a stalled result keeps its fields
   `MCBS_ASSERT_NEXT(a_result_held, rsp_stall, $stable(pin_ff) && $stable(act_ff))
endmodule

[sim/mcbs_checker.sv]
module mcbs_checker
   import mcbs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mcbs_req_if req_mon,
   mcbs_rsp_if rsp_mon,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int pending,
   output int errors
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [OUT_W-1:0] pin_levels;
      logic [OUT_W-1:0] active_mask;
   } bank_view_type;

   // predicted bank state, one entry per channel
   logic lvl_now [CHANNELS];
   logic lvl_next [CHANNELS];
   logic [HP_W-1:0] ticks_seen [CHANNELS];
   logic [HP_W-1:0] half_per [CHANNELS];
   logic [REP_W-1:0] blinks_loaded [CHANNELS];
   logic [REP_W-1:0] blinks_left [CHANNELS];
   logic [OUT_W-1:0] polarity;

   bank_view_type queued_views [$];
   bank_view_type want;
   bank_view_type seen;
   int error_count = 0;

   assign errors = error_count;

   task automatic clear_bank();
      for (int c = 0; c < CHANNELS; c++) begin
         lvl_now[c] = 1'b0;
         lvl_next[c] = 1'b0;
         ticks_seen[c] = '0;
         half_per[c] = '0;
         blinks_loaded[c] = '0;
         blinks_left[c] = '0;
      end
      polarity = '0;
   endtask

   task automatic tick_channel(input int c);
      if (half_per[c] != '0) begin
         ticks_seen[c] = ticks_seen[c] + 1'b1;
         if (ticks_seen[c] == half_per[c]) begin
            if (lvl_next[c]) begin
               lvl_now[c] = 1'b1;
               lvl_next[c] = 1'b0;
            end else begin
               // on-to-off toggle spends a blink unless endless
               if (blinks_loaded[c] != '0) begin
                  blinks_left[c] = blinks_left[c] - 1'b1;
                  if (blinks_left[c] == '0) begin
                     blinks_loaded[c] = '0;
                     half_per[c] = '0;
                  end
               end
               lvl_now[c] = 1'b0;
               lvl_next[c] = 1'b1;
            end
            ticks_seen[c] = '0;
         end
      end
   endtask

   task automatic predict_bank_view(input logic cmd, input logic [CHAN_W-1:0] ch,
                                    input logic on, input logic [REP_W-1:0] rep,
                                    input logic [HP_W-1:0] hp, output bank_view_type view);
      if (cmd == CMD_START) begin
         if (ch < CHANNELS) begin
            lvl_now[ch] = on;
            lvl_next[ch] = !on;
            blinks_loaded[ch] = rep;
            blinks_left[ch] = rep;
            half_per[ch] = hp;
            ticks_seen[ch] = '0;
         end
      end else begin
         for (int c = 0; c < CHANNELS; c++) tick_channel(c);
      end
      view.pin_levels = '0;
      view.active_mask = '0;
      for (int c = 0; c < CHANNELS && c < OUT_W; c++) begin
         view.pin_levels[c] = lvl_now[c];
         view.active_mask[c] = (half_per[c] != '0);
      end
      view.pin_levels = view.pin_levels ^ polarity;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_bank();
         queued_views.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == ADDR_ACTIVE_LOW_MASK)
            polarity = csr_pwdata[OUT_W-1:0];
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (queued_views.size() == 0) begin
               $error("unexpected result: pin_levels %h active_mask %h",
                      rsp_mon.pin_levels, rsp_mon.active_mask);
               error_count++;
            end else begin
               want = queued_views.pop_front();
               if (rsp_mon.pin_levels !== want.pin_levels) begin
                  $error("pin_levels mismatch: expected %h, actual %h",
                         want.pin_levels, rsp_mon.pin_levels);
                  error_count++;
               end
               if (rsp_mon.active_mask !== want.active_mask) begin
                  $error("active_mask mismatch: expected %h, actual %h",
                         want.active_mask, rsp_mon.active_mask);
                  error_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_bank_view(req_mon.command, req_mon.channel, req_mon.initial_on,
                              req_mon.repeat_count, req_mon.half_period, seen);
            queued_views.push_back(seen);
         end
      end
      pending <= queued_views.size();
   end

endmodule

[sim/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mcbs_pkg::*;

   localparam int RANDOM_PER_PHASE = 470;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   mcbs_req_if req_chan ();
   mcbs_rsp_if rsp_chan ();

   int pending;
   int errors;

   // idle odds in percent, changed per phase
   int send_idle_pct = 0;
   int take_stall_pct = 0;

   // running tallies for the closing summary
   int starts_sent = 0;
   int ticks_sent = 0;
   int polarity_writes = 0;

   logic [OUT_W-1:0] phase_polarity [3];

   multi_channel_blink_sequencer dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // watches both channels and the register port, predicts and compares
   mcbs_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_mon(req_chan),
      .rsp_mon(rsp_chan),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .pending(pending),
      .errors(errors)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // safety net against a hung handshake
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // result side: random back-pressure, new decision every falling edge
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= take_stall_pct);
      end
   end

   // one request transaction; entered and left on a falling edge, valid left high
   // so that back-to-back transactions never drop it in between
   task automatic drive_item(input logic cmd, input logic [CHAN_W-1:0] ch,
                             input logic on, input logic [REP_W-1:0] rep,
                             input logic [HP_W-1:0] hp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.channel <= ch;
      req_chan.initial_on <= on;
      req_chan.repeat_count <= rep;
      req_chan.half_period <= hp;
      do @(posedge clock); while (!req_chan.ready);
      if (cmd == CMD_START) starts_sent++;
      else ticks_sent++;
      @(negedge clock);
   endtask

   // mostly short half-periods and small repeat counts so that toggles and
   // the end of a pattern come often; now and then the full field range
   task automatic drive_random_item();
      logic cmd;
      logic [REP_W-1:0] rep;
      logic [HP_W-1:0] hp;
      cmd = ($urandom_range(99) < 35) ? CMD_START : CMD_TICK;
      rep = ($urandom_range(9) == 0) ? REP_W'($urandom_range(255)) : REP_W'($urandom_range(4));
      hp = ($urandom_range(9) == 0) ? HP_W'($urandom_range(65535)) : HP_W'($urandom_range(5));
      // fields still random on ticks, where they must be ignored
      drive_item(cmd, CHAN_W'($urandom_range(7)), 1'($urandom_range(1)), rep, hp);
   endtask

   // stop sending and hold off until every result is back
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // setup-then-access register write; only issued while the block is drained
   task automatic program_polarity(input logic [OUT_W-1:0] mask);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_ACTIVE_LOW_MASK;
      // upper bits carry noise, the block keeps only the low byte
      csr_pwdata <= {24'($urandom), mask};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      polarity_writes++;
   endtask

   initial begin
      // every input known from time zero
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_TICK;
      req_chan.channel = '0;
      req_chan.initial_on = 1'b0;
      req_chan.repeat_count = '0;
      req_chan.half_period = '0;

      phase_polarity[0] = 8'hFF;
      phase_polarity[1] = 8'h00;
      phase_polarity[2] = OUT_W'($urandom_range(255));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part: mixed polarity, sender and receiver both idle now and then
      send_idle_pct = 32;
      take_stall_pct = 83;
      program_polarity(8'h5A);

      // tick on an idle bank with every ignored field at its top value
      drive_item(CMD_TICK, 3'd7, 1'b1, 8'hFF, 16'hFFFF);
      // endless blink at the fastest rate
      drive_item(CMD_START, 3'd0, 1'b1, 8'd0, 16'd1);
      // slowest, longest pattern, starting off
      drive_item(CMD_START, 3'd7, 1'b0, 8'd255, 16'hFFFF);
      // zero half-period holds the level
      drive_item(CMD_START, 3'd1, 1'b1, 8'd1, 16'd0);
      drive_item(CMD_START, 3'd5, 1'b0, 8'd0, 16'd0);
      // single blink, runs out on the first on-to-off toggle
      drive_item(CMD_START, 3'd2, 1'b1, 8'd1, 16'd1);
      // two blinks starting off, ends after four toggles
      drive_item(CMD_START, 3'd3, 1'b0, 8'd2, 16'd2);
      drive_item(CMD_START, 3'd4, 1'b1, 8'd3, 16'd3);
      drive_item(CMD_START, 3'd6, 1'b0, 8'd128, 16'h8000);
      repeat (9) drive_item(CMD_TICK, 3'd0, 1'b0, 8'd0, 16'd0);
      // restart a finished channel whose next level was left on
      drive_item(CMD_START, 3'd2, 1'b0, 8'd1, 16'd1);
      repeat (3) drive_item(CMD_TICK, 3'd5, 1'b1, 8'hAA, 16'h5555);
      // restart a running channel mid-pattern
      drive_item(CMD_START, 3'd0, 1'b0, 8'd2, 16'd1);
      drive_item(CMD_TICK, 3'd2, 1'b0, 8'h55, 16'hAAAA);
      drain_results();

      // random phases, each under its own polarity and idle pattern
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 32;
               take_stall_pct = 83;
            end
            1: begin
               send_idle_pct = 83;
               take_stall_pct = 32;
            end
            default: begin
               send_idle_pct = 0;
               take_stall_pct = 0;
            end
         endcase
         program_polarity(phase_polarity[p]);
         repeat (RANDOM_PER_PHASE) drive_random_item();
         // pause the sender until the bank has answered everything
         drain_results();
      end

      repeat (10) @(negedge clock);

      $display("covered %0d transactions: %0d pattern starts and %0d ticks",
               starts_sent + ticks_sent, starts_sent, ticks_sent);
      $display("polarity register written %0d times, all-ones and all-zeros included",
               polarity_writes);
      if (errors == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/mcbs_pkg.sv
sv/mcbs_req_if.sv
sv/mcbs_rsp_if.sv
sv/mcbs_channel.sv
sv/multi_channel_blink_sequencer.sv
sim/mcbs_checker.sv
sim/testbench.sv
